@@ rtl/rbia_pkg.sv @@
// Shared constants, types and helpers for the rotor bitmap id allocator.
package rbia_pkg;

    localparam int ID_WORDS_DEF = 32;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int RID_W        = 10;
    localparam int GID_W        = 11;
    localparam int ADDR_MAX_W   = 8;

    // mode codes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic                    we;
        logic [ADDR_MAX_W-1:0]   waddr;
        logic [WORD_BITS-1:0]    wdata;
        logic                    re;
        logic [ADDR_MAX_W-1:0]   raddr;
    } rbia_ram_req_t;

    // lowest clear bit of a word; 31 when only bit 31 is clear or none is
    function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/rbia_bitmap_ram.sv @@
// Used-bitmap memory: one write port, one registered read port, per-word valid bits.
module rbia_bitmap_ram #(
    parameter int ID_WORDS = rbia_pkg::ID_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rbia_pkg::rbia_ram_req_t           req,
    output logic [rbia_pkg::WORD_BITS-1:0]    rdata
);
    import rbia_pkg::*;

    localparam int WW = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;

    logic [WORD_BITS-1:0] mem [ID_WORDS];
    logic [ID_WORDS-1:0]  valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[WW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.waddr[WW-1:0]] <= 1'b1;
        end
    end

    // never-written words read as all free
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= valid_reg[req.raddr[WW-1:0]] ? mem[req.raddr[WW-1:0]] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rbia_ctrl.sv @@
// Allocator control: rotor scan over full flags, read-modify-write of bitmap words, result register.
module rbia_ctrl #(
    parameter int ID_WORDS = rbia_pkg::ID_WORDS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_mode,
    input  logic [rbia_pkg::RID_W-1:0]       in_rid,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rbia_pkg::GID_W-1:0]       out_gid,
    output logic                             out_full,
    output rbia_pkg::rbia_ram_req_t          ram_req,
    input  logic [rbia_pkg::WORD_BITS-1:0]   ram_rdata
);
    import rbia_pkg::*;

    localparam int WW = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
    localparam logic [WW-1:0]    LAST_WORD = WW'(ID_WORDS - 1);
    localparam logic [GID_W-1:0] NO_ID     = GID_W'(ID_WORDS * WORD_BITS);
    localparam logic [8:0]       WORDS_CNT = 9'(ID_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [RID_W-1:0]     rid_reg, rid_next;
    logic [WW-1:0]        cand_reg, cand_next;
    logic [WW-1:0]        cnt_reg, cnt_next;
    logic [WW-1:0]        rotor_reg, rotor_next;
    logic [ID_WORDS-1:0]  wfull_reg, wfull_next;
    logic                 oval_reg, oval_next;
    logic [GID_W-1:0]     ogid_reg, ogid_next;
    logic                 ofull_reg, ofull_next;

    logic                 out_free;
    logic [BIT_W-1:0]     rel_word;
    logic                 rel_in_range;
    logic [BIT_W-1:0]     free_bit;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] rel_word_data;

    assign out_free      = !oval_reg || out_ready;
    assign rel_word      = rid_reg[RID_W-1:BIT_W];
    assign rel_in_range  = {4'b0, rel_word} < WORDS_CNT;
    assign free_bit      = lowest_clear(ram_rdata);
    assign alloc_word    = ram_rdata | (WORD_BITS'(1) << free_bit);
    assign rel_word_data = ram_rdata & ~(WORD_BITS'(1) << rid_reg[BIT_W-1:0]);

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        rid_next   = rid_reg;
        cand_next  = cand_reg;
        cnt_next   = cnt_reg;
        rotor_next = rotor_reg;
        wfull_next = wfull_reg;
        oval_next  = oval_reg;
        ogid_next  = ogid_reg;
        ofull_next = ofull_reg;
        ram_req    = '0;

        if (oval_reg && out_ready) begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    mode_next  = in_mode;
                    rid_next   = in_rid;
                    cand_next  = rotor_reg;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (mode_reg == MODE_RELEASE) begin
                    if (rel_in_range) begin
                        cand_next     = WW'(rel_word);
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_MAX_W'(rel_word);
                        state_next    = ST_MODIFY;
                    end else if (out_free) begin
                        oval_next  = 1'b1;
                        ogid_next  = NO_ID;
                        ofull_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end else if (!wfull_reg[cand_reg]) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_MAX_W'(cand_reg);
                    state_next    = ST_MODIFY;
                end else if (cnt_reg == LAST_WORD) begin
                    if (out_free) begin
                        oval_next  = 1'b1;
                        ogid_next  = NO_ID;
                        ofull_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cand_next = (cand_reg == LAST_WORD) ? '0 : cand_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ADDR_MAX_W'(cand_reg);
                    oval_next     = 1'b1;
                    ofull_next    = 1'b0;
                    state_next    = ST_IDLE;
                    if (mode_reg == MODE_RELEASE) begin
                        ram_req.wdata       = rel_word_data;
                        wfull_next[cand_reg] = 1'b0;
                        ogid_next           = NO_ID;
                    end else begin
                        ram_req.wdata       = alloc_word;
                        wfull_next[cand_reg] = &alloc_word;
                        rotor_next          = cand_reg;
                        ogid_next           = GID_W'({cand_reg, free_bit});
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rotor_reg <= '0;
            wfull_reg <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rotor_reg <= rotor_next;
            wfull_reg <= wfull_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        rid_reg   <= rid_next;
        cand_reg  <= cand_next;
        cnt_reg   <= cnt_next;
        ogid_reg  <= ogid_next;
        ofull_reg <= ofull_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = oval_reg;
    assign out_gid   = ogid_reg;
    assign out_full  = ofull_reg;

endmodule

@@ rtl/rotor_bitmap_id_allocator.sv @@
// Rotor bitmap id allocator top level: stream ports, control and bitmap memory.
//
// Allocates and releases ids out of a used-bitmap of ID_WORDS words of 32 bits
// held in a single-port-write, registered-read memory. A word on s_ carries a
// request: tuser is the mode (0 allocate, 1 release), tdata the id to release.
// Every request yields one word on m_: tdata the granted id (ID_WORDS*32, cut to
// 11 bits, on release or when the table is full), tuser the full flag.
// A release, or an allocation whose rotor word has a free bit, reads the word in
// the scan state, then writes it back and loads the result register in the modify
// state once that register is free; no new request is taken before that. A release
// beyond the table answers from the scan state. When the rotor word is full, the
// scan passes up to ID_WORDS-1 full words by their flags, or reports a full table.
// The result register lets the next request be taken while a result waits.
// The bitmap reads as all free right after reset; no clearing pass is needed.
module rotor_bitmap_id_allocator #(
    parameter int ID_WORDS = rbia_pkg::ID_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] release_id
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] granted_id
    output logic        m_tuser    // [0] table_full
);
    import rbia_pkg::*;

    rbia_ram_req_t        ram_req;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [GID_W-1:0]     gid;

    rbia_ctrl #(
        .ID_WORDS (ID_WORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_rid    (s_tdata[RID_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gid   (gid),
        .out_full  (m_tuser),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    rbia_bitmap_ram #(
        .ID_WORDS (ID_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rdata   (ram_rdata)
    );

    assign m_tdata = {5'b0, gid};

endmodule
